/* rtl/jtke_pkg.sv */
// Shared types, constants and byte classification for the JSON key extractor.
package jtke_pkg;

	localparam int KEY_MAX_BYTES = 32;
	localparam int MAX_DEPTH_DEF = 255;
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;

	localparam logic [15:0] CP_HI_MIN = 16'hD800;
	localparam logic [15:0] CP_HI_MAX = 16'hDBFF;
	localparam logic [15:0] CP_LO_MIN = 16'hDC00;
	localparam logic [15:0] CP_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_REPL   = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP   = 21'h010000;

	typedef enum logic [2:0] {
		ST_VALUE     = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_MALFORMED = 3'd3,
		ST_CONTAINER = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LEN = 3'd0,
		CFG_KEY_W0  = 3'd1,
		CFG_KEY_W1  = 3'd2,
		CFG_KEY_W2  = 3'd3,
		CFG_KEY_W3  = 3'd4,
		CFG_MAX_VB  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ws;
		logic       delim;
		logic       hex_ok;
		logic [3:0] hex_v;
	} cls_t;

	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       run_last;
	} rslt_t;

	typedef struct packed {
		rslt_t [4:0] lane;
		logic  [4:0] keep;
	} pkt_t;

	function automatic logic f_is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic cls_t f_classify(input logic [7:0] c, input logic last);
		cls_t r;
		logic dig;
		logic alpha;
		dig = (c >= 8'h30) && (c <= 8'h39);
		alpha = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
		r.data = c;
		r.last = last;
		r.ws = f_is_ws(c);
		r.delim = f_is_ws(c) || (c == CH_COMMA) || (c == CH_RBRACE) || (c == CH_RBRACK);
		r.hex_ok = dig || alpha;
		r.hex_v = dig ? c[3:0] : c[3:0] + 4'd9;
		return r;
	endfunction

endpackage

/* rtl/jtke_front.sv */
// Input side: accepts bytes, classifies them and queues them for the parser.
module jtke_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    in_byte,
	input  logic          doc_last,
	output logic          fq_valid,
	output jtke_pkg::cls_t fq_ent,
	input  logic          fq_pop
);
	import jtke_pkg::*;

	cls_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign full = (cnt_q == 2'd2);
	assign fq_valid = (cnt_q != 2'd0);
	assign fq_ent = ent_q[rp_q];
	assign wr_en = push && !full;
	assign rd_en = fq_pop && fq_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wp_q <= !wp_q;
			end
			if (rd_en) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wp_q] <= f_classify(in_byte, doc_last);
		end
	end

endmodule

/* rtl/jtke_core.sv */
// Parser core: document state machine, string unescaping and key matching.
module jtke_core #(
	parameter int MAX_DEPTH = jtke_pkg::MAX_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fq_valid,
	input  jtke_pkg::cls_t fq_ent,
	output logic           fq_pop,
	input  logic [5:0]     key_len,
	input  logic [255:0]   key_vec,
	input  logic [15:0]    max_vb,
	input  logic           pk_ready,
	output logic           pk_load,
	output jtke_pkg::pkt_t pk
);
	import jtke_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_LIM = DW'(MAX_DEPTH);
	localparam logic [6:0] KMAX7 = 7'(KEY_MAX_BYTES);

	localparam logic [3:0] ESC_IDLE  = 4'd0;
	localparam logic [3:0] ESC_BSL   = 4'd1;
	localparam logic [3:0] ESC_HEX0  = 4'd2;
	localparam logic [3:0] ESC_HEX1  = 4'd3;
	localparam logic [3:0] ESC_HEX2  = 4'd4;
	localparam logic [3:0] ESC_HEX3  = 4'd5;
	localparam logic [3:0] ESC_LBSL  = 4'd6;
	localparam logic [3:0] ESC_LU    = 4'd7;
	localparam logic [3:0] ESC_LHEX0 = 4'd8;
	localparam logic [3:0] ESC_LHEX1 = 4'd9;
	localparam logic [3:0] ESC_LHEX2 = 4'd10;
	localparam logic [3:0] ESC_LHEX3 = 4'd11;

	typedef enum logic [12:0] {
		PH_START         = 13'b0000000000001,
		PH_MEMBER        = 13'b0000000000010,
		PH_KEY_STR       = 13'b0000000000100,
		PH_COLON         = 13'b0000000001000,
		PH_VALUE_WS      = 13'b0000000010000,
		PH_VAL_STR       = 13'b0000000100000,
		PH_VAL_SCALAR    = 13'b0000001000000,
		PH_SKIP_STR      = 13'b0000010000000,
		PH_SKIP_SCALAR   = 13'b0000100000000,
		PH_SKIP_CONT     = 13'b0001000000000,
		PH_SKIP_CONT_STR = 13'b0010000000000,
		PH_AFTER         = 13'b0100000000000,
		PH_DONE          = 13'b1000000000000
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [3:0]    esc_q, esc_d;
	logic [15:0]   hex_q, hex_d;
	logic [9:0]    pend_q, pend_d;
	logic [2:0]    hcnt_q, hcnt_d;
	logic [7:0]    held_q [6];
	logic [DW-1:0] depth_q, depth_d;
	logic [5:0]    kp_q, kp_d;
	logic          km_q, km_d;
	logic [15:0]   vc_q, vc_d;
	logic [3:0]    rcnt_q, rcnt_d;
	logic          endp_q, endp_d;
	logic [7:0]    rp_q [7];
	logic [2:0]    rp_cnt_q, rp_cnt_d;

	logic          op_rp, op_end, op_new, go;
	cls_t          cur;
	logic [7:0]    c;
	logic [15:0]   hx;

	logic [3:0]    s_esc;
	logic [15:0]   s_hex;
	logic [9:0]    s_pend;
	logic [2:0]    s_hcnt;
	logic          s_hold, s_hwr, s_em, s_raw, s_close, s_bad, s_brk;
	logic [20:0]   s_cp;

	logic          hwr, e_on, e_raw, dec, rpl, rpl_c, to_after, to_member, begin_str;
	logic          reset_all, val_mode, key_mode;
	logic [20:0]   e_cp;
	status_t       dec_st;
	logic [15:0]   vc_base;
	logic [2:0]    em_n;
	logic [7:0]    lb [4];
	logic [6:0]    kps;
	logic [5:0]    kpi;
	logic [16:0]   vcs;
	logic [3:0]    keep_d;
	logic [2:0]    nkeep;
	logic [4:0]    ord;

	assign op_rp = (rp_cnt_q != 3'd0);
	assign op_end = !op_rp && endp_q;
	assign op_new = !op_rp && !endp_q && fq_valid;
	assign go = pk_ready && (op_rp || op_end || op_new);
	assign fq_pop = go && op_new;
	assign pk_load = go;
	assign cur = op_rp ? f_classify(rp_q[0], 1'b0) : fq_ent;
	assign c = cur.data;
	assign hx = {hex_q[11:0], cur.hex_v};

	// One byte through the string unescaper.
	always_comb begin
		s_esc = esc_q;
		s_hex = hex_q;
		s_pend = pend_q;
		s_hcnt = hcnt_q;
		s_hold = 1'b0;
		s_hwr = 1'b0;
		s_em = 1'b0;
		s_raw = 1'b0;
		s_cp = '0;
		s_close = 1'b0;
		s_bad = 1'b0;
		s_brk = 1'b0;
		case (esc_q)
			ESC_IDLE: begin
				if (c == CH_QUOTE) begin
					s_close = 1'b1;
				end else if (c == CH_BSL) begin
					s_esc = ESC_BSL;
				end else begin
					s_em = 1'b1;
					s_raw = 1'b1;
				end
			end
			ESC_BSL: begin
				s_esc = ESC_IDLE;
				case (c)
					CH_QUOTE, CH_BSL, CH_SLASH: begin
						s_em = 1'b1;
						s_raw = 1'b1;
					end
					CH_LC_B: begin
						s_em = 1'b1;
						s_cp = {13'd0, CH_BS};
					end
					CH_LC_F: begin
						s_em = 1'b1;
						s_cp = {13'd0, CH_FF};
					end
					CH_LC_N: begin
						s_em = 1'b1;
						s_cp = {13'd0, CH_LF};
					end
					CH_LC_R: begin
						s_em = 1'b1;
						s_cp = {13'd0, CH_CR};
					end
					CH_LC_T: begin
						s_em = 1'b1;
						s_cp = {13'd0, CH_TAB};
					end
					CH_LC_U: begin
						s_hex = '0;
						s_esc = ESC_HEX0;
					end
					default: begin
						s_bad = 1'b1;
					end
				endcase
			end
			ESC_HEX0, ESC_HEX1, ESC_HEX2, ESC_HEX3: begin
				if (!cur.hex_ok) begin
					s_bad = 1'b1;
				end else begin
					s_hex = hx;
					s_esc = esc_q + 4'd1;
					if (esc_q == ESC_HEX3) begin
						if (hx >= CP_HI_MIN && hx <= CP_HI_MAX) begin
							s_pend = hx[9:0];
							s_hcnt = 3'd0;
						end else begin
							s_esc = ESC_IDLE;
							s_em = 1'b1;
							s_cp = {5'd0, hx};
						end
					end
				end
			end
			ESC_LBSL: begin
				if (c == CH_BSL) begin
					s_hold = 1'b1;
					s_esc = ESC_LU;
				end else begin
					s_brk = 1'b1;
				end
			end
			ESC_LU: begin
				if (c == CH_LC_U) begin
					s_hold = 1'b1;
					s_hex = '0;
					s_esc = ESC_LHEX0;
				end else begin
					s_brk = 1'b1;
				end
			end
			ESC_LHEX0, ESC_LHEX1, ESC_LHEX2, ESC_LHEX3: begin
				if (!cur.hex_ok) begin
					s_brk = 1'b1;
				end else begin
					s_hex = hx;
					if (esc_q == ESC_LHEX3) begin
						if (hx < CP_LO_MIN || hx > CP_LO_MAX) begin
							s_brk = 1'b1;
						end else begin
							s_em = 1'b1;
							s_cp = CP_SUPP + {1'b0, pend_q, hx[9:0]};
							s_pend = '0;
							s_hcnt = 3'd0;
							s_esc = ESC_IDLE;
						end
					end else begin
						s_hold = 1'b1;
						s_esc = esc_q + 4'd1;
					end
				end
			end
			default: begin
				s_esc = ESC_IDLE;
				s_bad = 1'b1;
			end
		endcase
		if (s_hold && hcnt_q < 3'd6) begin
			s_hwr = 1'b1;
			s_hcnt = hcnt_q + 3'd1;
		end
		if (s_brk) begin
			s_em = 1'b1;
			s_raw = 1'b0;
			s_cp = CP_REPL;
			s_hcnt = 3'd0;
			s_pend = '0;
			s_esc = ESC_IDLE;
			s_hwr = 1'b0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		esc_d = esc_q;
		hex_d = hex_q;
		pend_d = pend_q;
		hcnt_d = hcnt_q;
		depth_d = depth_q;
		kp_d = kp_q;
		km_d = km_q;
		vc_d = vc_q;
		vc_base = vc_q;
		rcnt_d = rcnt_q;
		endp_d = endp_q;
		rp_cnt_d = rp_cnt_q;
		hwr = 1'b0;
		e_on = 1'b0;
		e_raw = 1'b0;
		e_cp = '0;
		dec = 1'b0;
		dec_st = ST_VALUE;
		rpl = 1'b0;
		rpl_c = 1'b0;
		to_after = 1'b0;
		to_member = 1'b0;
		begin_str = 1'b0;
		reset_all = 1'b0;
		if (go && op_rp) begin
			rp_cnt_d = rp_cnt_q - 3'd1;
		end
		if (go && op_end) begin
			if (phase_q != PH_DONE) begin
				if (phase_q == PH_MEMBER || phase_q == PH_AFTER || phase_q == PH_SKIP_SCALAR) begin
					dec = 1'b1;
					dec_st = ST_NOT_FOUND;
				end else if (phase_q == PH_VAL_SCALAR) begin
					dec = 1'b1;
					dec_st = ST_FOUND;
				end else if (phase_q == PH_VAL_STR && esc_q >= ESC_LBSL && esc_q <= ESC_LHEX3) begin
					e_on = 1'b1;
					e_cp = CP_REPL;
					rpl = 1'b1;
					hcnt_d = 3'd0;
					pend_d = '0;
					esc_d = ESC_IDLE;
				end else begin
					dec = 1'b1;
					dec_st = ST_MALFORMED;
				end
			end
			reset_all = !rpl;
		end else if (go) begin
			if (op_new) begin
				endp_d = cur.last;
			end
			case (phase_q)
				PH_START: begin
					if (!cur.ws) begin
						if (c == CH_LBRACE) begin
							phase_d = PH_MEMBER;
						end else begin
							dec = 1'b1;
							dec_st = ST_MALFORMED;
						end
					end
				end
				PH_MEMBER: begin
					to_member = 1'b1;
				end
				PH_KEY_STR, PH_VAL_STR, PH_SKIP_STR, PH_SKIP_CONT_STR: begin
					esc_d = s_esc;
					hex_d = s_hex;
					pend_d = s_pend;
					hcnt_d = s_hcnt;
					hwr = s_hwr;
					e_on = s_em;
					e_raw = s_raw;
					e_cp = s_cp;
					rpl = s_brk;
					rpl_c = 1'b1;
					if (s_bad) begin
						dec = 1'b1;
						dec_st = ST_MALFORMED;
					end else if (s_close) begin
						case (phase_q)
							PH_KEY_STR: begin
								km_d = km_q && (kp_q == key_len) && ({1'b0, key_len} <= KMAX7);
								phase_d = PH_COLON;
							end
							PH_VAL_STR: begin
								dec = 1'b1;
								dec_st = ST_FOUND;
							end
							PH_SKIP_STR: begin
								phase_d = PH_AFTER;
							end
							default: begin
								phase_d = PH_SKIP_CONT;
							end
						endcase
					end
				end
				PH_COLON: begin
					if (!cur.ws) begin
						if (c == CH_COLON) begin
							phase_d = PH_VALUE_WS;
						end else begin
							dec = 1'b1;
							dec_st = ST_MALFORMED;
						end
					end
				end
				PH_VALUE_WS: begin
					if (!cur.ws) begin
						if (km_q) begin
							vc_d = '0;
							vc_base = '0;
							if (c == CH_QUOTE) begin
								phase_d = PH_VAL_STR;
								begin_str = 1'b1;
							end else if (c == CH_LBRACE || c == CH_LBRACK) begin
								dec = 1'b1;
								dec_st = ST_CONTAINER;
							end else if (cur.delim) begin
								dec = 1'b1;
								dec_st = ST_FOUND;
							end else begin
								e_on = 1'b1;
								e_raw = 1'b1;
								phase_d = PH_VAL_SCALAR;
							end
						end else begin
							if (c == CH_QUOTE) begin
								phase_d = PH_SKIP_STR;
								begin_str = 1'b1;
							end else if (c == CH_LBRACE || c == CH_LBRACK) begin
								phase_d = PH_SKIP_CONT;
								depth_d = DW'(1);
							end else if (cur.delim) begin
								to_after = 1'b1;
							end else begin
								phase_d = PH_SKIP_SCALAR;
							end
						end
					end
				end
				PH_VAL_SCALAR: begin
					if (cur.delim) begin
						dec = 1'b1;
						dec_st = ST_FOUND;
					end else begin
						e_on = 1'b1;
						e_raw = 1'b1;
					end
				end
				PH_SKIP_SCALAR: begin
					if (cur.delim) begin
						to_after = 1'b1;
					end
				end
				PH_SKIP_CONT: begin
					if (c == CH_QUOTE) begin
						phase_d = PH_SKIP_CONT_STR;
						begin_str = 1'b1;
					end else if (c == CH_LBRACE || c == CH_LBRACK) begin
						if (depth_q >= DEPTH_LIM) begin
							dec = 1'b1;
							dec_st = ST_MALFORMED;
						end else begin
							depth_d = depth_q + DW'(1);
						end
					end else if (c == CH_RBRACE || c == CH_RBRACK) begin
						if (depth_q <= DW'(1)) begin
							depth_d = '0;
							phase_d = PH_AFTER;
						end else begin
							depth_d = depth_q - DW'(1);
						end
					end
				end
				PH_AFTER: begin
					to_after = 1'b1;
				end
				default: begin
				end
			endcase
			if (to_after) begin
				if (cur.ws) begin
					phase_d = PH_AFTER;
				end else if (c == CH_COMMA) begin
					phase_d = PH_MEMBER;
				end else begin
					to_member = 1'b1;
				end
			end
			if (to_member) begin
				if (cur.ws) begin
					phase_d = PH_MEMBER;
				end else if (c == CH_RBRACE) begin
					dec = 1'b1;
					dec_st = ST_NOT_FOUND;
				end else if (c == CH_QUOTE) begin
					phase_d = PH_KEY_STR;
					kp_d = '0;
					km_d = 1'b1;
					begin_str = 1'b1;
				end else begin
					dec = 1'b1;
					dec_st = ST_MALFORMED;
				end
			end
			if (begin_str) begin
				esc_d = ESC_IDLE;
				hcnt_d = 3'd0;
				pend_d = '0;
				hex_d = '0;
			end
		end

		// UTF-8 encoding of the emitted code point.
		em_n = 3'd0;
		for (int i = 0; i < 4; i++) begin
			lb[i] = 8'h00;
		end
		if (e_on) begin
			if (e_raw) begin
				em_n = 3'd1;
				lb[0] = c;
			end else if (e_cp < 21'h80) begin
				em_n = 3'd1;
				lb[0] = e_cp[7:0];
			end else if (e_cp < 21'h800) begin
				em_n = 3'd2;
				lb[0] = {3'b110, e_cp[10:6]};
				lb[1] = {2'b10, e_cp[5:0]};
			end else if (e_cp < CP_SUPP) begin
				em_n = 3'd3;
				lb[0] = {4'b1110, e_cp[15:12]};
				lb[1] = {2'b10, e_cp[11:6]};
				lb[2] = {2'b10, e_cp[5:0]};
			end else begin
				em_n = 3'd4;
				lb[0] = {5'b11110, e_cp[20:18]};
				lb[1] = {2'b10, e_cp[17:12]};
				lb[2] = {2'b10, e_cp[11:6]};
				lb[3] = {2'b10, e_cp[5:0]};
			end
		end

		key_mode = (phase_q == PH_KEY_STR);
		val_mode = (phase_q == PH_VALUE_WS) || (phase_q == PH_VAL_STR) ||
			(phase_q == PH_VAL_SCALAR);
		keep_d = 4'd0;
		kps = '0;
		kpi = '0;
		vcs = '0;
		for (int i = 0; i < 4; i++) begin
			kps = {1'b0, kp_q} + 7'(i);
			kpi = (kps > 7'd63) ? 6'd63 : kps[5:0];
			vcs = {1'b0, vc_base} + 17'(i);
			if (vcs > 17'h0FFFF) begin
				vcs = 17'h0FFFF;
			end
			if (3'(i) < em_n) begin
				if (key_mode) begin
					if (!(kpi < key_len && {1'b0, kpi} < KMAX7 &&
						key_vec[{kpi[4:0], 3'b000} +: 8] == lb[i])) begin
						km_d = 1'b0;
					end
				end
				if (val_mode && vcs[15:0] < max_vb) begin
					keep_d[i] = 1'b1;
				end
			end
		end
		if (e_on && key_mode) begin
			kps = {1'b0, kp_q} + {4'd0, em_n};
			kp_d = (kps > 7'd63) ? 6'd63 : kps[5:0];
		end
		if (e_on && val_mode) begin
			vcs = {1'b0, vc_base} + {14'd0, em_n};
			vc_d = (vcs > 17'h0FFFF) ? 16'hFFFF : vcs[15:0];
		end

		// Result packet, limited to eight results per input byte.
		ord = op_new ? 5'd0 : {1'b0, rcnt_q};
		nkeep = 3'd0;
		for (int i = 0; i < 4; i++) begin
			pk.lane[i].data = lb[i];
			pk.lane[i].status = ST_VALUE;
			pk.lane[i].run_last = 1'b0;
			pk.keep[i] = 1'b0;
			if (keep_d[i]) begin
				pk.keep[i] = (ord < 5'd8);
				ord = ord + 5'd1;
			end
		end
		pk.lane[4].data = 8'h00;
		pk.lane[4].status = dec_st;
		pk.lane[4].run_last = 1'b1;
		pk.keep[4] = dec && (ord < 5'd8);
		if (dec) begin
			ord = ord + 5'd1;
		end
		nkeep = 3'd0;
		if (go) begin
			rcnt_d = (ord > 5'd8) ? 4'd8 : ord[3:0];
		end
		if (dec) begin
			phase_d = PH_DONE;
		end
		if (rpl) begin
			rp_cnt_d = hcnt_q + {2'd0, rpl_c};
		end
		if (reset_all) begin
			phase_d = PH_START;
			esc_d = ESC_IDLE;
			hex_d = '0;
			pend_d = '0;
			hcnt_d = 3'd0;
			depth_d = '0;
			kp_d = '0;
			km_d = 1'b1;
			vc_d = '0;
			endp_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			esc_q <= ESC_IDLE;
			hex_q <= '0;
			pend_q <= '0;
			hcnt_q <= 3'd0;
			depth_q <= '0;
			kp_q <= '0;
			km_q <= 1'b1;
			vc_q <= '0;
			rcnt_q <= '0;
			endp_q <= 1'b0;
			rp_cnt_q <= 3'd0;
		end else begin
			phase_q <= phase_d;
			esc_q <= esc_d;
			hex_q <= hex_d;
			pend_q <= pend_d;
			hcnt_q <= hcnt_d;
			depth_q <= depth_d;
			kp_q <= kp_d;
			km_q <= km_d;
			vc_q <= vc_d;
			rcnt_q <= rcnt_d;
			endp_q <= endp_d;
			rp_cnt_q <= rp_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hwr) begin
			held_q[hcnt_q] <= c;
		end
		if (rpl) begin
			for (int i = 0; i < 6; i++) begin
				rp_q[i] <= (3'(i) < hcnt_q) ? held_q[i] : c;
			end
			rp_q[6] <= c;
		end else if (go && op_rp) begin
			for (int i = 0; i < 6; i++) begin
				rp_q[i] <= rp_q[i+1];
			end
		end
	end

endmodule

/* rtl/jtke_rslt.sv */
// Result side: drains result packets into the output queue, one result per cycle while it has room.
module jtke_rslt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pk_load,
	input  jtke_pkg::pkt_t pk,
	output logic           pk_ready,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic [2:0]     status,
	output logic           run_last
);
	import jtke_pkg::*;

	rslt_t      lane_q [5];
	logic [4:0] mask_q;
	logic [4:0] mask_nx;
	rslt_t      oq_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       pop_fire;
	logic       mv;
	logic [2:0] sel;

	assign pop_fire = pop && (cnt_q != 2'd0);
	assign mv = (mask_q != 5'd0) && ((cnt_q != 2'd2) || pop_fire);
	assign empty = (cnt_q == 2'd0);
	assign out_byte = oq_q[rp_q].data;
	assign status = oq_q[rp_q].status;
	assign run_last = oq_q[rp_q].run_last;

	always_comb begin
		sel = 3'd0;
		for (int i = 4; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = 3'(i);
			end
		end
		mask_nx = mask_q;
		if (mv) begin
			mask_nx[sel] = 1'b0;
		end
		pk_ready = (mask_nx == 5'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 5'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			mask_q <= pk_load ? pk.keep : mask_nx;
			if (mv) begin
				wp_q <= !wp_q;
			end
			if (pop_fire) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, mv} - {1'b0, pop_fire};
		end
	end

	always_ff @(posedge clk) begin
		if (pk_load) begin
			for (int i = 0; i < 5; i++) begin
				lane_q[i] <= pk.lane[i];
			end
		end
		if (mv) begin
			oq_q[wp_q] <= lane_q[sel];
		end
	end

endmodule

/* rtl/json_top_level_key_extractor_top.sv */
// Top level of the JSON top-level key extractor: configuration registers and wiring.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          in_byte, doc_last
// result    out        empty / pop          out_byte, status, run_last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each input byte passes through the parser core once; each further UTF-8 byte of
// a decoded code point is drained as its own result at the result drain. A byte
// flagged last is followed by a separate end-of-document check step, and a broken
// surrogate escape replays its held bytes at one per cycle while the result side is ready.
// Reset clears all parse state and loads the configuration defaults.
// Input and result sides each have a two-entry queue, so either may stall alone.
module json_top_level_key_extractor_top #(
	parameter int MAX_DEPTH = jtke_pkg::MAX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        doc_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic [2:0]  status,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [jtke_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);
	import jtke_pkg::*;

	logic [5:0]  key_len_q;
	logic [63:0] key_w_q [KEY_WORDS];
	logic [15:0] max_vb_q;
	logic [255:0] key_vec;
	logic        fq_valid;
	cls_t        fq_ent;
	logic        fq_pop;
	logic        pk_ready;
	logic        pk_load;
	pkt_t        pk;

	assign cfg_ready = 1'b1;
	assign key_vec = {key_w_q[3], key_w_q[2], key_w_q[1], key_w_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= '0;
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_w_q[i] <= '0;
			end
			max_vb_q <= 16'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KEY_LEN: key_len_q <= cfg_data[5:0];
				CFG_KEY_W0: key_w_q[0] <= cfg_data;
				CFG_KEY_W1: key_w_q[1] <= cfg_data;
				CFG_KEY_W2: key_w_q[2] <= cfg_data;
				CFG_KEY_W3: key_w_q[3] <= cfg_data;
				CFG_MAX_VB: max_vb_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	jtke_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.doc_last(doc_last),
		.fq_valid(fq_valid),
		.fq_ent(fq_ent),
		.fq_pop(fq_pop)
	);

	jtke_core #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fq_valid(fq_valid),
		.fq_ent(fq_ent),
		.fq_pop(fq_pop),
		.key_len(key_len_q),
		.key_vec(key_vec),
		.max_vb(max_vb_q),
		.pk_ready(pk_ready),
		.pk_load(pk_load),
		.pk(pk)
	);

	jtke_rslt u_rslt (
		.clk(clk),
		.arst_n(arst_n),
		.pk_load(pk_load),
		.pk(pk),
		.pk_ready(pk_ready),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.status(status),
		.run_last(run_last)
	);

endmodule
